FILE: hdl/grid_manhattan_distance_transform_macros.svh
// Assertion macros used by the file that carries checks.
`ifndef GRID_MANHATTAN_DISTANCE_TRANSFORM_MACROS_SVH
`define GRID_MANHATTAN_DISTANCE_TRANSFORM_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GMDT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GMDT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/gmdt_pkg.sv
package gmdt_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    localparam int ACTION_W = 2;
    localparam int ROW_W    = 6;
    localparam int COL_W    = 6;
    localparam int SIZE_W   = 7;
    localparam int DIST_W   = 7;

    typedef logic [DIST_W-1:0] t_dist;
    typedef logic [SIZE_W-1:0] t_size;

    localparam t_dist DIST_MAX    = 7'd127;
    localparam t_size SIZE_RESET  = 7'd64;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD    = 2'd0,
        ACT_COMPUTE = 2'd1,
        ACT_READ    = 2'd2
    } t_action;

    localparam logic KIND_COMPUTE = 1'b0;
    localparam logic KIND_READ    = 1'b1;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // Operands of one relaxation step: the cell's own value and up to two
    // neighbors, each of which is one step further away.
    typedef struct packed {
        t_dist base;
        logic  use_a;
        t_dist a;
        logic  use_b;
        t_dist b;
    } t_relax_req;

endpackage

FILE: hdl/gmdt_in_if.sv
interface gmdt_in_if import gmdt_pkg::*;;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic                cell_value;

    modport source (output valid, action, row, col, cell_value, input ready);
    modport sink   (input valid, action, row, col, cell_value, output ready);
endinterface

FILE: hdl/gmdt_out_if.sv
interface gmdt_out_if import gmdt_pkg::*;;
    logic              valid;
    logic              ready;
    logic              result_kind;
    logic [DIST_W-1:0] distance;
    logic              no_source;

    modport source (output valid, result_kind, distance, no_source, input ready);
    modport sink   (input valid, result_kind, distance, no_source, output ready);
endinterface

FILE: hdl/gmdt_ram.sv
module gmdt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [AW-1:0]          i_waddr,
    input  logic [WIDTH-1:0]       i_wdata,
    input  logic [AW-1:0]          i_raddr,
    output logic [WIDTH-1:0]       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/gmdt_relax.sv
module gmdt_relax import gmdt_pkg::*; (
    input  t_relax_req i_req,
    output t_dist      o_dist
);
    t_dist a_inc;
    t_dist b_inc;
    t_dist m;

    // Distances saturate at the maximum code, so a far neighbor stays far.
    always_comb begin
        a_inc = (i_req.a == DIST_MAX) ? DIST_MAX : i_req.a + t_dist'(1);
        b_inc = (i_req.b == DIST_MAX) ? DIST_MAX : i_req.b + t_dist'(1);
        m = i_req.base;
        if (i_req.use_a && (a_inc < m)) begin
            m = a_inc;
        end
        if (i_req.use_b && (b_inc < m)) begin
            m = b_inc;
        end
        o_dist = m;
    end
endmodule

FILE: hdl/grid_manhattan_distance_transform.sv
// City-block distance transform. Load words write one source bit of the grid
// and leave the block idle. A compute word runs a forward and a backward raster
// scan over the configured rows*cols cells; each cell has a read state, reading
// the distance RAM, and a write state, relaxing against its neighbors through the
// shared min unit and writing back. Its result word is offered after the backward
// scan, once the output is free. A read word waits for the registered read of the
// distance RAM. The grid memories need no clearing after reset; a read of a cell
// never computed returns whatever the RAM holds.
`include "grid_manhattan_distance_transform_macros.svh"

module grid_manhattan_distance_transform import gmdt_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gmdt_in_if.sink           i_item,
    gmdt_out_if.source        o_result,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [SIZE_W-1:0] i_cfg_data
);
    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_FWD_RD,
        S_FWD_WR,
        S_BWD_RD,
        S_BWD_WR,
        S_DONE
    } t_state;

    function automatic logic [AW-1:0] cell_addr(input t_size r, input t_size c);
        return AW'(int'(r) * MAX_COLS + int'(c));
    endfunction

    t_state        r_state;
    t_size         r_rows;
    t_size         r_cols;
    t_size         r_row;
    t_size         r_col;
    t_dist         r_prev;
    logic          r_found;
    logic          r_any;
    logic [AW-1:0] r_addr;
    logic          r_inside;
    logic          r_out_valid;
    logic          r_out_kind;
    t_dist         r_out_dist;
    logic          r_out_nosrc;

    t_size         rows_used;
    t_size         cols_used;
    t_size         in_row;
    t_size         in_col;
    logic          in_inside;
    logic [AW-1:0] in_addr;
    logic [AW-1:0] cur_addr;
    logic          in_fire;
    logic          out_free;
    logic          last_col;
    logic          last_row;
    t_action       act;
    logic          scan_in_grid;
    logic          out_is_compute;
    logic          out_pending;

    logic          src_we;
    logic          src_rd;
    logic          dist_we;
    logic [AW-1:0] dist_raddr_a;
    logic [AW-1:0] dist_raddr_b;
    t_dist         dist_rd_a;
    t_dist         dist_rd_b;
    t_relax_req    relax_req;
    t_dist         relax_dist;

    // A size of zero acts as one; a size beyond the array acts as its maximum.
    always_comb begin
        if (r_rows == '0) begin
            rows_used = t_size'(1);
        end else if (int'(r_rows) > MAX_ROWS) begin
            rows_used = t_size'(MAX_ROWS);
        end else begin
            rows_used = r_rows;
        end
        if (r_cols == '0) begin
            cols_used = t_size'(1);
        end else if (int'(r_cols) > MAX_COLS) begin
            cols_used = t_size'(MAX_COLS);
        end else begin
            cols_used = r_cols;
        end
    end

    assign in_row    = t_size'(i_item.row);
    assign in_col    = t_size'(i_item.col);
    assign in_inside = (in_row < rows_used) && (in_col < cols_used);
    assign in_addr   = cell_addr(in_row, in_col);
    assign cur_addr  = cell_addr(r_row, r_col);
    assign act       = t_action'(i_item.action);

    assign i_item.ready = (r_state == S_IDLE);
    assign in_fire      = i_item.valid && i_item.ready;
    assign out_free     = !r_out_valid || o_result.ready;
    assign last_col     = (r_col + t_size'(1)) == cols_used;
    assign last_row     = (r_row + t_size'(1)) == rows_used;

    assign scan_in_grid   = (r_row < rows_used) && (r_col < cols_used);
    assign out_is_compute = r_out_valid && (r_out_kind == KIND_COMPUTE);
    assign out_pending    = (r_state == S_DONE) || (r_state == S_RD_WAIT);

    assign src_we  = in_fire && (act == ACT_LOAD) && in_inside;
    assign dist_we = (r_state == S_FWD_WR) || (r_state == S_BWD_WR);

    always_comb begin
        unique case (r_state)
            S_IDLE:    dist_raddr_a = in_addr;
            S_RD_WAIT: dist_raddr_a = r_addr;
            S_FWD_RD:  dist_raddr_a = cur_addr - AW'(MAX_COLS);
            default:   dist_raddr_a = cur_addr;
        endcase
    end
    assign dist_raddr_b = cur_addr + AW'(MAX_COLS);

    // Forward scan looks up and left; backward scan looks down and right.
    always_comb begin
        if (r_state == S_FWD_WR) begin
            relax_req.base  = src_rd ? '0 : DIST_MAX;
            relax_req.use_a = (r_row != '0);
            relax_req.a     = dist_rd_a;
            relax_req.use_b = (r_col != '0);
            relax_req.b     = r_prev;
        end else begin
            relax_req.base  = dist_rd_a;
            relax_req.use_a = !last_row;
            relax_req.a     = dist_rd_b;
            relax_req.use_b = !last_col;
            relax_req.b     = r_prev;
        end
    end

    gmdt_ram #(.WIDTH(1), .DEPTH(CELLS)) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (src_we),
        .i_waddr (in_addr),
        .i_wdata (i_item.cell_value),
        .i_raddr (cur_addr),
        .o_rdata (src_rd)
    );

    // Two copies of the distance store give two reads per cycle.
    gmdt_ram #(.WIDTH(DIST_W), .DEPTH(CELLS)) u_dist_ram_a (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (cur_addr),
        .i_wdata (relax_dist),
        .i_raddr (dist_raddr_a),
        .o_rdata (dist_rd_a)
    );

    gmdt_ram #(.WIDTH(DIST_W), .DEPTH(CELLS)) u_dist_ram_b (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (cur_addr),
        .i_wdata (relax_dist),
        .i_raddr (dist_raddr_b),
        .o_rdata (dist_rd_b)
    );

    gmdt_relax u_relax (
        .i_req  (relax_req),
        .o_dist (relax_dist)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rows      <= SIZE_RESET;
            r_cols      <= SIZE_RESET;
            r_any       <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // The states that offer a new word handle the valid flag themselves.
            if (r_out_valid && o_result.ready && !out_pending) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_ROWS: r_rows <= i_cfg_data;
                    REG_COLS: r_cols <= i_cfg_data;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        unique case (act)
                            ACT_COMPUTE: begin
                                r_row   <= '0;
                                r_col   <= '0;
                                r_found <= 1'b0;
                                r_state <= S_FWD_RD;
                            end
                            ACT_READ: begin
                                r_addr   <= in_addr;
                                r_inside <= in_inside;
                                r_state  <= S_RD_WAIT;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_RD_WAIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= KIND_READ;
                        r_out_dist  <= r_inside ? dist_rd_a : DIST_MAX;
                        r_out_nosrc <= !r_any;
                        r_state     <= S_IDLE;
                    end
                end
                S_FWD_RD: begin
                    r_state <= S_FWD_WR;
                end
                S_FWD_WR: begin
                    r_prev  <= relax_dist;
                    r_found <= r_found | src_rd;
                    if (!last_col) begin
                        r_col   <= r_col + t_size'(1);
                        r_state <= S_FWD_RD;
                    end else if (!last_row) begin
                        r_col   <= '0;
                        r_row   <= r_row + t_size'(1);
                        r_state <= S_FWD_RD;
                    end else begin
                        r_col   <= cols_used - t_size'(1);
                        r_row   <= rows_used - t_size'(1);
                        r_state <= S_BWD_RD;
                    end
                end
                S_BWD_RD: begin
                    r_state <= S_BWD_WR;
                end
                S_BWD_WR: begin
                    r_prev <= relax_dist;
                    if (r_col != '0) begin
                        r_col   <= r_col - t_size'(1);
                        r_state <= S_BWD_RD;
                    end else if (r_row != '0) begin
                        r_col   <= cols_used - t_size'(1);
                        r_row   <= r_row - t_size'(1);
                        r_state <= S_BWD_RD;
                    end else begin
                        r_any   <= r_found;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= KIND_COMPUTE;
                        r_out_dist  <= '0;
                        r_out_nosrc <= !r_any;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.result_kind = r_out_kind;
    assign o_result.distance    = r_out_dist;
    assign o_result.no_source   = r_out_nosrc;

    `GMDT_ASSERT_SAME(a_scan_in_bounds, dist_we, scan_in_grid, "scan out of grid")
    `GMDT_ASSERT_SAME(a_compute_zero, out_is_compute, (r_out_dist == '0), "compute distance set")
    `GMDT_ASSERT_SAME(a_done_flag, (r_state == S_DONE), (r_any == r_found), "source flag lost")
    `GMDT_ASSERT_NEXT(a_no_stray, (!r_out_valid && !out_pending), (!r_out_valid), "stray result")
endmodule
